[rtl/core/jsu_pkg.sv]
// Shared constants and types of the Jacobi symbol unit.
package jsu_pkg;

	localparam int unsigned DEFAULT_OPERAND_WIDTH = 64;
	localparam int unsigned PORT_WIDTH            = 64;

	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_POS  = 2'b01;
	localparam logic [1:0] SYM_NEG  = 2'b11;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic a_zero;
		logic a_odd;
		logic borrow;
		logic b_one;
		logic flip_shift;
		logic flip_swap;
	} alu_status_t;

endpackage

[rtl/core/jsu_alu.sv]
// Shared subtract/compare unit of the Jacobi symbol unit, with sign-flip tests.
module jsu_alu #(
	parameter int unsigned OPERAND_WIDTH = jsu_pkg::DEFAULT_OPERAND_WIDTH
) (
	input  logic [OPERAND_WIDTH-1:0] a,
	input  logic [OPERAND_WIDTH-1:0] b,
	output logic [OPERAND_WIDTH-1:0] diff,
	output jsu_pkg::alu_status_t     status
);

	logic [OPERAND_WIDTH:0] sub;

	// One wide subtract serves as both difference and a < b compare.
	assign sub  = {1'b0, a} - {1'b0, b};
	assign diff = sub[OPERAND_WIDTH-1:0];

	always_comb begin
		status.a_zero     = (a == '0);
		status.a_odd      = a[0];
		status.borrow     = sub[OPERAND_WIDTH];
		status.b_one      = (b == {{(OPERAND_WIDTH-1){1'b0}}, 1'b1});
		// b mod 8 is 3 or 5
		status.flip_shift = b[1] ^ b[2];
		// both operands 3 mod 4
		status.flip_swap  = a[1] & a[0] & b[1] & b[0];
	end

endmodule

[rtl/core/jacobi_symbol_unit.sv]
// Top level of the Jacobi symbol unit: sequencer, operand registers and output word.
//
// Computes the Jacobi symbol (a/b) of a signed operand a over an odd modulus b.
// Input channel: in_valid/in_ready carry one word of value_a (two's complement)
// and modulus_b (unsigned); only the low OPERAND_WIDTH bits of each are used.
// Output channel: out_valid/out_ready carry one word of symbol (-1, 0 or 1 as a
// two's complement 2-bit value) and invalid_modulus for every input word.
// A zero or even modulus gives symbol 0 with invalid_modulus set and skips the
// run steps. Otherwise the binary algorithm runs on one shared subtractor:
// each cycle either halves an even a, swaps a and b when a < b, or replaces a
// by a - b, until a reaches zero. The number of steps is data dependent, and one
// word is in work at a time; in_ready is high only while the sequencer is idle.
// The finished result goes into an output register; the sequencer can take the
// next word while that result still waits. If the receiver stalls and the
// output register is still full when the next result is ready, the sequencer
// holds in its finish state until the old word is taken.
// Reset (arst_n low, asynchronous) empties the output register and returns the
// sequencer to idle; no other state survives between words.
module jacobi_symbol_unit #(
	parameter int unsigned OPERAND_WIDTH = jsu_pkg::DEFAULT_OPERAND_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [jsu_pkg::PORT_WIDTH-1:0] value_a,
	input  logic [jsu_pkg::PORT_WIDTH-1:0]    modulus_b,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [1:0]                 symbol,
	output logic                              invalid_modulus
);

	jsu_pkg::state_t state_q;

	logic [OPERAND_WIDTH-1:0] a_q;
	logic [OPERAND_WIDTH-1:0] b_q;
	logic                     neg_q;     // accumulated sign is negative
	logic                     inv_q;     // modulus rejected
	logic                     out_valid_q;
	logic [1:0]               symbol_q;
	logic                     invalid_q;

	logic [OPERAND_WIDTH-1:0] a_raw;
	logic [OPERAND_WIDTH-1:0] b_raw;
	logic [OPERAND_WIDTH-1:0] a_mag;
	logic                     a_neg;
	logic                     load_neg;
	logic [OPERAND_WIDTH-1:0] diff;
	jsu_pkg::alu_status_t     status;
	logic                     accept;
	logic                     out_free;
	logic [1:0]               result_sym;

	assign a_raw    = value_a[OPERAND_WIDTH-1:0];
	assign b_raw    = modulus_b[OPERAND_WIDTH-1:0];
	assign a_neg    = a_raw[OPERAND_WIDTH-1];
	assign a_mag    = a_neg ? (~a_raw + {{(OPERAND_WIDTH-1){1'b0}}, 1'b1}) : a_raw;
	// negative a flips the sign when b mod 4 is 3
	assign load_neg = a_neg & b_raw[1] & b_raw[0];

	assign in_ready = (state_q == jsu_pkg::ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	jsu_alu #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_alu (
		.a     (a_q),
		.b     (b_q),
		.diff  (diff),
		.status(status)
	);

	// b ended at 1: the symbol is the accumulated sign, else 0
	always_comb begin
		if (inv_q || !status.b_one) begin
			result_sym = jsu_pkg::SYM_ZERO;
		end else if (neg_q) begin
			result_sym = jsu_pkg::SYM_NEG;
		end else begin
			result_sym = jsu_pkg::SYM_POS;
		end
	end

	// Sequencer: one shared subtract per cycle until a reaches zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsu_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				jsu_pkg::ST_IDLE: begin
					if (accept) begin
						// reject a zero or even modulus at once
						state_q <= b_raw[0] ? jsu_pkg::ST_RUN : jsu_pkg::ST_FINISH;
					end
				end
				jsu_pkg::ST_RUN: begin
					if (status.a_zero) begin
						state_q <= jsu_pkg::ST_FINISH;
					end
				end
				jsu_pkg::ST_FINISH: begin
					if (out_free) begin
						state_q <= jsu_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= jsu_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Operand registers: load, then halve, swap or subtract.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q   <= a_mag;
			b_q   <= b_raw;
			neg_q <= load_neg;
			inv_q <= ~b_raw[0];
		end else if (state_q == jsu_pkg::ST_RUN && !status.a_zero) begin
			if (!status.a_odd) begin
				// strip a factor of two
				a_q   <= a_q >> 1;
				neg_q <= neg_q ^ status.flip_shift;
			end else if (status.borrow) begin
				// a < b: swap by reciprocity
				a_q   <= b_q;
				b_q   <= a_q;
				neg_q <= neg_q ^ status.flip_swap;
			end else begin
				a_q <= diff;
			end
		end
	end

	// Output register: holds the word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == jsu_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == jsu_pkg::ST_FINISH && out_free) begin
			symbol_q  <= result_sym;
			invalid_q <= inv_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign symbol          = symbol_q;
	assign invalid_modulus = invalid_q;

endmodule
